@@ rtl/core/flsa_pkg.sv @@
// Shared types, codes and constants for the free list slot allocator.
package flsa_pkg;

    localparam int POOL_SLOTS_DEF = 256;

    localparam int OBJ_SIZE_W  = 13;
    localparam int REQ_SIZE_W  = 13;
    localparam int SLOT_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int LIVE_W      = 9;
    localparam int TOTAL_W     = 32;

    localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RST = 13'd64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE_LIVE = 2'd3;

    typedef struct packed {
        logic init_step;
        logic load;
        logic commit;
    } flsa_cmd_t;

    typedef struct packed {
        logic init_last;
        logic out_valid;
    } flsa_sts_t;

endpackage

@@ rtl/core/flsa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module flsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/flsa_ctrl.sv @@
// Sequencing state machine for the free list slot allocator.
module flsa_ctrl
    import flsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      out_stall,
    input  flsa_sts_t sts,
    output flsa_cmd_t cmd
);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_free;

    assign out_free = !sts.out_valid || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.init_step = 1'b0;
        cmd.load      = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/flsa_dp.sv @@
// Datapath: link memory, free head, counters, config register and result register.
module flsa_dp
    import flsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  flsa_cmd_t             cmd,
    output flsa_sts_t             sts,
    input  logic                  cfg_we,
    input  logic [OBJ_SIZE_W-1:0] cfg_data,
    input  logic                  op,
    input  logic [REQ_SIZE_W-1:0] request_size,
    input  logic [SLOT_W-1:0]     slot_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SLOT_W-1:0]     granted_slot,
    output logic [STATUS_W-1:0]   status,
    output logic [LIVE_W-1:0]     live_count,
    output logic [TOTAL_W-1:0]    total_count
);

    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int LINK_W = IDX_W + 1;
    localparam int CMP_W  = (LINK_W > SLOT_W) ? LINK_W : SLOT_W;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_SLOTS - 1);

    logic [IDX_W-1:0]      init_cnt_reg;
    logic [LINK_W-1:0]     head_reg;
    logic [LINK_W-1:0]     head_next;
    logic [LIVE_W-1:0]     live_reg;
    logic [LIVE_W-1:0]     live_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [OBJ_SIZE_W-1:0] obj_size_reg;
    logic                  op_reg;
    logic [REQ_SIZE_W-1:0] req_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     granted_reg;
    logic [SLOT_W-1:0]     granted_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [LINK_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [LINK_W-1:0]     ram_rdata;
    logic                  too_large;
    logic                  pool_empty;
    logic                  slot_in_range;

    flsa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign too_large     = (req_reg > obj_size_reg);
    assign pool_empty    = (head_reg >= LINK_NULL);
    assign slot_in_range = (CMP_W'(slot_reg) < CMP_W'(POOL_SLOTS));

    assign ram_re = cmd.load && (op == OP_ALLOC);

    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = init_cnt_reg;
        ram_wdata    = (init_cnt_reg == LAST_IDX) ? LINK_NULL
                                                  : LINK_W'(init_cnt_reg) + 1'b1;
        head_next    = head_reg;
        live_next    = live_reg;
        total_next   = total_reg;
        granted_next = '0;
        status_next  = STATUS_OK;
        if (cmd.init_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.commit)
        begin
            if (op_reg == OP_ALLOC)
            begin
                priority if (too_large)
                begin
                    status_next = STATUS_TOO_LARGE;
                end
                else if (pool_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = head_reg[IDX_W-1:0];
                    ram_wdata    = LINK_NULL;
                    head_next    = ram_rdata;
                    live_next    = live_reg + 1'b1;
                    total_next   = total_reg + 1'b1;
                    granted_next = SLOT_W'(head_reg);
                end
            end
            else
            begin
                priority if (live_reg == '0)
                begin
                    status_next = STATUS_NONE_LIVE;
                end
                else if (slot_in_range)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(slot_reg);
                    ram_wdata = head_reg;
                    head_next = LINK_W'(slot_reg);
                    live_next = live_reg - 1'b1;
                end
                else
                begin
                    status_next = STATUS_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            head_reg      <= '0;
            live_reg      <= '0;
            total_reg     <= '0;
            obj_size_reg  <= OBJ_SIZE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                obj_size_reg <= cfg_data;
            end
            head_reg      <= head_next;
            live_reg      <= live_next;
            total_reg     <= total_next;
            out_valid_reg <= cmd.commit || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            req_reg  <= request_size;
            slot_reg <= slot_index;
        end
        if (cmd.commit)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign sts.init_last = (init_cnt_reg == LAST_IDX);
    assign sts.out_valid = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;
    assign live_count   = live_reg;
    assign total_count  = total_reg;

endmodule

@@ rtl/core/free_list_slot_allocator.sv @@
// Top level of the free list slot allocator.
// Each item is accepted in the idle state, which for an allocation issues
// the read of the head slot's link from the registered-read link memory;
// the execute state then commits the pop or push and loads the result
// register. A result waits in that register while the next item is
// accepted; an item whose result cannot be loaded yet holds in the block
// until the waiting result is taken. After reset the block fills the link
// memory with a chain in which each slot links to the next and the last
// slot links to null, with in_stall high; object_size writes are taken at any time.
module free_list_slot_allocator
    import flsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [OBJ_SIZE_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [REQ_SIZE_W-1:0] request_size,
    input  logic [SLOT_W-1:0]     slot_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SLOT_W-1:0]     granted_slot,
    output logic [STATUS_W-1:0]   status,
    output logic [LIVE_W-1:0]     live_count,
    output logic [TOTAL_W-1:0]    total_count
);

    flsa_cmd_t cmd;
    flsa_sts_t sts;

    flsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    flsa_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .op           (op),
        .request_size (request_size),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_slot (granted_slot),
        .status       (status),
        .live_count   (live_count),
        .total_count  (total_count)
    );

`ifndef SYNTH
    a_commit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("result committed over a waiting result");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while another is at work");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result shown without a commit");

    a_no_load_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_step |-> !cmd.load && !cmd.commit)
        else $error("item handled during link memory fill");
`endif

endmodule
